FILE: sv/slt_pkg.sv
// Shared types, constants and helpers of the source lexer tokenizer.
`default_nettype none
package slt_pkg;

   localparam int unsigned MAX_SOURCE_BYTES = 1048576;
   localparam int unsigned MAX_LINE         = 65535;
   localparam int unsigned QUEUE_DEPTH      = 4;

   localparam logic [20:0] OFF_MAX   = 21'(MAX_SOURCE_BYTES);
   localparam logic [19:0] START_MAX = 20'(MAX_SOURCE_BYTES - 1);
   localparam logic [15:0] LINE_MAX  = 16'(MAX_LINE);
   localparam logic [34:0] NUM_MAX   = 35'd2147483647;

   localparam logic [5:0] K_LPAREN = 6'd0;
   localparam logic [5:0] K_RPAREN = 6'd1;
   localparam logic [5:0] K_LBRACE = 6'd2;
   localparam logic [5:0] K_RBRACE = 6'd3;
   localparam logic [5:0] K_LBRACK = 6'd4;
   localparam logic [5:0] K_RBRACK = 6'd5;
   localparam logic [5:0] K_COMMA  = 6'd6;
   localparam logic [5:0] K_MINUS  = 6'd7;
   localparam logic [5:0] K_PLUS   = 6'd8;
   localparam logic [5:0] K_SEMI   = 6'd9;
   localparam logic [5:0] K_STAR   = 6'd10;
   localparam logic [5:0] K_BANG   = 6'd11;
   localparam logic [5:0] K_BANGEQ = 6'd12;
   localparam logic [5:0] K_EQ     = 6'd13;
   localparam logic [5:0] K_EQEQ   = 6'd14;
   localparam logic [5:0] K_LT     = 6'd15;
   localparam logic [5:0] K_LE     = 6'd16;
   localparam logic [5:0] K_GT     = 6'd17;
   localparam logic [5:0] K_GE     = 6'd18;
   localparam logic [5:0] K_SLASH  = 6'd19;
   localparam logic [5:0] K_IDENT  = 6'd20;
   localparam logic [5:0] K_STRING = 6'd21;
   localparam logic [5:0] K_NUMBER = 6'd22;
   localparam logic [5:0] K_KW0    = 6'd23;
   localparam logic [5:0] K_EOF    = 6'd32;

   localparam logic [2:0] E_OK         = 3'd0;
   localparam logic [2:0] E_UNEXPECTED = 3'd1;
   localparam logic [2:0] E_OPEN_STR   = 3'd2;
   localparam logic [2:0] E_BAD_CHAR   = 3'd3;
   localparam logic [2:0] E_BAD_ESC    = 3'd4;
   localparam logic [2:0] E_OVERFLOW   = 3'd5;

   localparam int unsigned KW_COUNT = 9;
   // keyword text stored reversed so character 0 sits in the low byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("dna"), 64'("esle"), 64'("nuf"), 64'("fi"), 64'("ro"),
      64'("ctup"), 64'("nruter"), 64'("rav"), 64'("elihw")};
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd4, 3'd3, 3'd2, 3'd2, 3'd4, 3'd6, 3'd3, 3'd5};

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [19:0] start;
      logic [20:0] len;
      logic [15:0] line;
      logic [30:0] val;
   } result_type;

   typedef struct packed {
      logic [1:0]            cnt;
      result_type [2:0]      res;
   } bundle_type;

   // keyword candidates that survive byte b at position pos
   function automatic logic [KW_COUNT-1:0] kw_keep(input logic [20:0] pos,
                                                   input logic [7:0] b);
      logic [KW_COUNT-1:0] m;
      logic [63:0]         t;
      m = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         t = KW_TEXT[k];
         m[k] = (pos < 21'(KW_LEN[k])) && (t[{pos[2:0], 3'b000} +: 8] == b);
      end
      return m;
   endfunction

   function automatic logic [5:0] id_kind(input logic [KW_COUNT-1:0] mask,
                                          input logic [20:0] len);
      logic [5:0] kind;
      kind = K_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (mask[k] && len == 21'(KW_LEN[k])) kind = K_KW0 + 6'(k);
      end
      return kind;
   endfunction

   function automatic result_type mk_result(input logic [5:0] kind,
                                            input logic [2:0] err,
                                            input logic [19:0] start,
                                            input logic [20:0] end_off,
                                            input logic [30:0] val,
                                            input logic [15:0] line);
      result_type r;
      r.kind  = kind;
      r.err   = err;
      r.start = start;
      r.len   = (end_off >= {1'b0, start}) ? end_off - {1'b0, start} : '0;
      r.line  = line;
      r.val   = val;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/slt_front.sv
// Lexer front end: scans one byte a cycle while take is high and builds the word bundle it causes.
`default_nettype none
module slt_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   take,
   input  wire  [7:0]            data_byte,
   input  wire                   has_byte,
   input  wire                   end_of_source,
   output logic                  bundle_valid,
   output slt_pkg::bundle_type   bundle
);

   localparam logic [3:0] M_IDLE     = 4'd0;
   localparam logic [3:0] M_BANG     = 4'd1;
   localparam logic [3:0] M_EQ       = 4'd2;
   localparam logic [3:0] M_LT       = 4'd3;
   localparam logic [3:0] M_GT       = 4'd4;
   localparam logic [3:0] M_SLASH    = 4'd5;
   localparam logic [3:0] M_COMMENT  = 4'd6;
   localparam logic [3:0] M_IDENT    = 4'd7;
   localparam logic [3:0] M_NUMBER   = 4'd8;
   localparam logic [3:0] M_STRING   = 4'd9;
   localparam logic [3:0] M_CH_OPEN  = 4'd10;
   localparam logic [3:0] M_CH_ESC   = 4'd11;
   localparam logic [3:0] M_CH_CLOSE = 4'd12;

   logic [3:0]  mode_ff, mode_in;
   logic [19:0] start_ff, start_in;
   logic [20:0] off_ff, off_in;
   logic [15:0] line_ff, line_in;
   logic [30:0] acc_ff, acc_in;
   logic [8:0]  mask_ff, mask_in;
   logic [7:0]  chr_ff, chr_in;
   logic        halt_ff, halt_in;

   logic [20:0] nxt;
   logic [19:0] eof_start;
   logic [34:0] acc_next;
   logic [3:0]  digit;
   logic [1:0]  cnt;
   logic        do_idle;
   logic        is_digit, is_alpha, is_word;
   logic [5:0]  op_kind;
   slt_pkg::bundle_type bnd;

   assign is_digit = (data_byte >= "0") && (data_byte <= "9");
   assign is_alpha = ((data_byte >= "a") && (data_byte <= "z")) ||
                     ((data_byte >= "A") && (data_byte <= "Z"));
   assign is_word  = is_alpha || is_digit || (data_byte == "_");
   assign digit    = 4'(data_byte - 8'h30);
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {31'd0, digit};
   assign nxt      = (off_ff < slt_pkg::OFF_MAX) ? off_ff + 21'd1 : slt_pkg::OFF_MAX;

   always_comb begin
      unique case (mode_ff)
         M_BANG:  op_kind = slt_pkg::K_BANG;
         M_EQ:    op_kind = slt_pkg::K_EQ;
         M_LT:    op_kind = slt_pkg::K_LT;
         default: op_kind = slt_pkg::K_GT;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      off_in   = off_ff;
      line_in  = line_ff;
      acc_in   = acc_ff;
      mask_in  = mask_ff;
      chr_in   = chr_ff;
      halt_in  = halt_ff;
      bnd      = '0;
      cnt      = '0;
      do_idle  = 1'b0;
      eof_start = '0;

      if (take && has_byte) begin
         if (halt_ff) begin
            off_in = nxt;
         end else begin
            unique case (mode_ff)
               M_IDLE: begin
                  do_idle = 1'b1;
               end
               M_BANG, M_EQ, M_LT, M_GT: begin
                  mode_in = M_IDLE;
                  if (data_byte == "=") begin
                     bnd.res[cnt] = slt_pkg::mk_result(op_kind + 6'd1, slt_pkg::E_OK,
                                                       start_in, nxt, '0, line_ff);
                     cnt = cnt + 2'd1;
                  end else begin
                     bnd.res[cnt] = slt_pkg::mk_result(op_kind, slt_pkg::E_OK,
                                                       start_in, off_ff, '0, line_ff);
                     cnt = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_SLASH: begin
                  if (data_byte == "/") begin
                     mode_in = M_COMMENT;
                  end else begin
                     mode_in = M_IDLE;
                     bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_SLASH, slt_pkg::E_OK,
                                                       start_in, off_ff, '0, line_ff);
                     cnt = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_COMMENT: begin
                  if (data_byte == 8'h0A) begin
                     mode_in = M_IDLE;
                     do_idle = 1'b1;
                  end
               end
               M_IDENT: begin
                  if (is_word) begin
                     mask_in = mask_ff & slt_pkg::kw_keep(off_ff - {1'b0, start_ff},
                                                          data_byte);
                  end else begin
                     mode_in = M_IDLE;
                     bnd.res[cnt] = slt_pkg::mk_result(
                        slt_pkg::id_kind(mask_ff, off_ff - {1'b0, start_ff}),
                        slt_pkg::E_OK, start_in, off_ff, '0, line_ff);
                     cnt = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_NUMBER: begin
                  if (is_digit) begin
                     if (acc_next > slt_pkg::NUM_MAX) begin
                        bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_OVERFLOW,
                                                          start_in, nxt, '0, line_ff);
                        cnt = cnt + 2'd1;
                        halt_in = 1'b1;
                        mode_in = M_IDLE;
                     end else begin
                        acc_in = acc_next[30:0];
                     end
                  end else begin
                     mode_in = M_IDLE;
                     bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_NUMBER, slt_pkg::E_OK,
                                                       start_in, off_ff, acc_ff, line_ff);
                     cnt = cnt + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_STRING: begin
                  if (data_byte == "\"") begin
                     mode_in = M_IDLE;
                     bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_STRING, slt_pkg::E_OK,
                                                       start_in, nxt, '0, line_ff);
                     cnt = cnt + 2'd1;
                  end else if (data_byte == 8'h0A && line_ff < slt_pkg::LINE_MAX) begin
                     line_in = line_ff + 16'd1;
                  end
               end
               M_CH_OPEN: begin
                  if (data_byte == "\\") begin
                     mode_in = M_CH_ESC;
                  end else begin
                     chr_in  = data_byte;
                     mode_in = M_CH_CLOSE;
                  end
               end
               M_CH_ESC: begin
                  if (data_byte == "'") begin
                     chr_in  = "'";
                     mode_in = M_CH_CLOSE;
                  end else if (data_byte == "n") begin
                     chr_in  = 8'h0A;
                     mode_in = M_CH_CLOSE;
                  end else begin
                     bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_BAD_ESC,
                                                       start_in, nxt, '0, line_ff);
                     cnt = cnt + 2'd1;
                     halt_in = 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               default: begin
                  mode_in = M_IDLE;
                  if (data_byte == "'") begin
                     bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_NUMBER, slt_pkg::E_OK,
                                                       start_in, nxt, {23'd0, chr_ff},
                                                       line_ff);
                  end else begin
                     bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_BAD_CHAR,
                                                       start_in, off_ff, '0, line_ff);
                     halt_in = 1'b1;
                  end
                  cnt = cnt + 2'd1;
               end
            endcase

            // a byte that opens a new lexeme
            if (do_idle) begin
               start_in = (off_ff < slt_pkg::OFF_MAX - 21'd1) ? off_ff[19:0]
                                                              : slt_pkg::START_MAX;
               unique case (data_byte)
                  "(", ")", "{", "}", "[", "]", ",", "-", "+", ";", "*": begin
                     unique case (data_byte)
                        "(":     bnd.res[cnt].kind = slt_pkg::K_LPAREN;
                        ")":     bnd.res[cnt].kind = slt_pkg::K_RPAREN;
                        "{":     bnd.res[cnt].kind = slt_pkg::K_LBRACE;
                        "}":     bnd.res[cnt].kind = slt_pkg::K_RBRACE;
                        "[":     bnd.res[cnt].kind = slt_pkg::K_LBRACK;
                        "]":     bnd.res[cnt].kind = slt_pkg::K_RBRACK;
                        ",":     bnd.res[cnt].kind = slt_pkg::K_COMMA;
                        "-":     bnd.res[cnt].kind = slt_pkg::K_MINUS;
                        "+":     bnd.res[cnt].kind = slt_pkg::K_PLUS;
                        ";":     bnd.res[cnt].kind = slt_pkg::K_SEMI;
                        default: bnd.res[cnt].kind = slt_pkg::K_STAR;
                     endcase
                     bnd.res[cnt] = slt_pkg::mk_result(bnd.res[cnt].kind, slt_pkg::E_OK,
                                                       start_in, nxt, '0, line_ff);
                     cnt = cnt + 2'd1;
                  end
                  "!":  mode_in = M_BANG;
                  "=":  mode_in = M_EQ;
                  "<":  mode_in = M_LT;
                  ">":  mode_in = M_GT;
                  "/":  mode_in = M_SLASH;
                  " ", 8'h0D, 8'h09: ;
                  8'h0A: begin
                     if (line_ff < slt_pkg::LINE_MAX) line_in = line_ff + 16'd1;
                  end
                  "'":  mode_in = M_CH_OPEN;
                  "\"": mode_in = M_STRING;
                  default: begin
                     if (is_digit) begin
                        acc_in  = {27'd0, digit};
                        mode_in = M_NUMBER;
                     end else if (is_alpha || data_byte == "_") begin
                        mask_in = slt_pkg::kw_keep('0, data_byte);
                        mode_in = M_IDENT;
                     end else begin
                        bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_UNEXPECTED,
                                                          start_in, nxt, '0, line_ff);
                        cnt = cnt + 2'd1;
                        halt_in = 1'b1;
                        mode_in = M_IDLE;
                     end
                  end
               endcase
            end
            off_in = nxt;
         end
      end

      if (take && end_of_source) begin
         // flush the pending lexeme, then EOF and clear all state
         if (!halt_in) begin
            unique case (mode_in)
               M_BANG, M_EQ, M_LT, M_GT: begin
                  unique case (mode_in)
                     M_BANG:  bnd.res[cnt].kind = slt_pkg::K_BANG;
                     M_EQ:    bnd.res[cnt].kind = slt_pkg::K_EQ;
                     M_LT:    bnd.res[cnt].kind = slt_pkg::K_LT;
                     default: bnd.res[cnt].kind = slt_pkg::K_GT;
                  endcase
                  bnd.res[cnt] = slt_pkg::mk_result(bnd.res[cnt].kind, slt_pkg::E_OK,
                                                    start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               M_SLASH: begin
                  bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_SLASH, slt_pkg::E_OK,
                                                    start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               M_IDENT: begin
                  bnd.res[cnt] = slt_pkg::mk_result(
                     slt_pkg::id_kind(mask_in, off_in - {1'b0, start_in}),
                     slt_pkg::E_OK, start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               M_NUMBER: begin
                  bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_NUMBER, slt_pkg::E_OK,
                                                    start_in, off_in, acc_in, line_in);
                  cnt = cnt + 2'd1;
               end
               M_STRING: begin
                  bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_OPEN_STR,
                                                    start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               M_CH_OPEN, M_CH_CLOSE: begin
                  bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_BAD_CHAR,
                                                    start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               M_CH_ESC: begin
                  bnd.res[cnt] = slt_pkg::mk_result('0, slt_pkg::E_BAD_ESC,
                                                    start_in, off_in, '0, line_in);
                  cnt = cnt + 2'd1;
               end
               default: ;
            endcase
         end
         eof_start = (off_in < slt_pkg::OFF_MAX - 21'd1) ? off_in[19:0]
                                                         : slt_pkg::START_MAX;
         bnd.res[cnt] = slt_pkg::mk_result(slt_pkg::K_EOF, slt_pkg::E_OK, eof_start,
                                           {1'b0, eof_start}, '0, line_in);
         cnt = cnt + 2'd1;
         mode_in  = M_IDLE;
         start_in = '0;
         off_in   = '0;
         line_in  = 16'd1;
         acc_in   = '0;
         mask_in  = '1;
         chr_in   = '0;
         halt_in  = 1'b0;
      end
      bnd.cnt = cnt;
   end

   assign bundle       = bnd;
   assign bundle_valid = take && (cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         off_ff   <= '0;
         line_ff  <= 16'd1;
         acc_ff   <= '0;
         mask_ff  <= '1;
         chr_ff   <= '0;
         halt_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         off_ff   <= off_in;
         line_ff  <= line_in;
         acc_ff   <= acc_in;
         mask_ff  <= mask_in;
         chr_ff   <= chr_in;
         halt_ff  <= halt_in;
      end
   end

`ifndef SYNTH
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      take && end_of_source |=> off_ff == '0 && mode_ff == M_IDLE && !halt_ff
                                && line_ff == 16'd1)
      else $error("state not cleared after end of source");
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> mode_ff == M_IDLE)
      else $error("halted lexer left a lexeme open");
`endif

endmodule
`default_nettype wire

FILE: sv/slt_queue.sv
// Short queue of result bundles between the front end and the output stage.
`default_nettype none
module slt_queue #(
   parameter int unsigned DEPTH = slt_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  slt_pkg::bundle_type   push_data,
   output logic                  full,
   input  wire                   pop,
   output logic                  empty,
   output slt_pkg::bundle_type   head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   slt_pkg::bundle_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

FILE: sv/slt_back.sv
// Output stage: holds one bundle and hands its results out one word at a time.
`default_nettype none
module slt_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_empty,
   input  slt_pkg::bundle_type   q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output slt_pkg::result_type   rsp_word,
   output logic                  rsp_last
);

   slt_pkg::bundle_type bnd_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       take_word, done;

   assign rsp_empty = !valid_ff;
   assign rsp_word  = bnd_ff.res[idx_ff];
   assign rsp_last  = (idx_ff == bnd_ff.cnt - 2'd1);
   assign take_word = rsp_pop && valid_ff;
   assign done      = take_word && rsp_last;
   // refill when the held bundle is gone or its last word leaves now
   assign q_pop     = !q_empty && (!valid_ff || done);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (take_word) begin
         idx_in   = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) bnd_ff <= q_head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTH
   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bnd_ff.cnt != 2'd0 && idx_ff < bnd_ff.cnt)
      else $error("output index outside held bundle");
`endif

endmodule
`default_nettype wire

FILE: sv/source_lexer_tokenizer_core.sv
// Top level of the source lexer tokenizer.
// Input side is a queue write port: drive req_data_byte, req_has_byte and
// req_end_of_source with req_push; the word is taken on a clock edge where
// req_push is high and req_full is low. A word with req_has_byte low and
// req_end_of_source low is a no-op.
// Result side is a queue read port: while rsp_empty is low the oldest token
// is on the rsp_ ports; rsp_pop takes it. rsp_last_of_run marks the final
// token caused by one input word (one word can cause up to three).
// The front end scans one byte per cycle, so one input word is taken every
// cycle while the bundle queue has room. A token passes through the bundle
// queue and the held bundle of the output stage before it shows on the rsp_
// ports. Output runs at one token per cycle while rsp_pop is high; each token
// of a word that causes two or three tokens leaves on its own pop.
// When rsp_pop stays low the bundle queue (QUEUE_DEPTH bundles plus one held
// at the output) fills and req_full rises; nothing is dropped.
// Synchronous reset empties the queue and returns the lexer to line 1,
// offset 0, no lexeme open. End of source emits EOF and returns the lexer to that state too.
`default_nettype none
module source_lexer_tokenizer_core #(
   parameter int unsigned QUEUE_DEPTH = slt_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_has_byte,
   input  wire         req_end_of_source,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [5:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [19:0] rsp_start_offset,
   output logic [20:0] rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic [30:0] rsp_number_value,
   output logic        rsp_last_of_run
);

   slt_pkg::bundle_type front_bundle, q_head;
   slt_pkg::result_type word;
   logic front_valid, q_full, q_empty, q_pop, take;

   assign take     = req_push && !q_full;
   assign req_full = q_full;

   slt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_data_byte),
      .has_byte      (req_has_byte),
      .end_of_source (req_end_of_source),
      .bundle_valid  (front_valid),
      .bundle        (front_bundle)
   );

   slt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_bundle),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   slt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (word),
      .rsp_last  (rsp_last_of_run)
   );

   assign rsp_token_kind   = word.kind;
   assign rsp_error_code   = word.err;
   assign rsp_start_offset = word.start;
   assign rsp_text_length  = word.len;
   assign rsp_line_number  = word.line;
   assign rsp_number_value = word.val;

endmodule
`default_nettype wire

FILE: tb/token_checker.sv
// Token checker: predicts the lexer's tokens from accepted words and compares them.
`timescale 1ns / 100ps
module token_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   input  wire         req_full,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_has_byte,
   input  wire         req_end_of_source,
   input  wire         rsp_empty,
   input  wire         rsp_pop,
   input  wire  [5:0]  rsp_token_kind,
   input  wire  [2:0]  rsp_error_code,
   input  wire  [19:0] rsp_start_offset,
   input  wire  [20:0] rsp_text_length,
   input  wire  [15:0] rsp_line_number,
   input  wire  [30:0] rsp_number_value,
   input  wire         rsp_last_of_run,
   output int          fail_count,
   output int          pending
);

   typedef enum logic [3:0] {
      LM_IDLE, LM_BANG, LM_EQ, LM_LT, LM_GT, LM_SLASH, LM_COMMENT,
      LM_IDENT, LM_NUMBER, LM_STRING, LM_CH_OPEN, LM_CH_ESC, LM_CH_CLOSE
   } lex_mode_type;

   typedef struct {
      slt_pkg::result_type tok;
      bit                  last;
   } token_word_type;

   localparam longint SRC_MAX = slt_pkg::MAX_SOURCE_BYTES;
   localparam string  KW_WORDS [slt_pkg::KW_COUNT] = '{
      "and", "else", "fun", "if", "or", "putc", "return", "var", "while"};

   token_word_type expected_tokens [$];

   lex_mode_type    mode;
   longint          lex_start;
   longint          rd_off;
   longint          line_cnt;
   longint          num_acc;
   bit [slt_pkg::KW_COUNT-1:0] kw_mask;
   logic [7:0]      ch_val;
   bit              halted;
   int              run_count;

   task automatic clear_lexer();
      mode      = LM_IDLE;
      lex_start = 0;
      rd_off    = 0;
      line_cnt  = 1;
      num_acc   = 0;
      kw_mask   = '1;
      ch_val    = 8'd0;
      halted    = 1'b0;
   endtask

   task automatic add_token(logic [5:0] kind, logic [2:0] err, longint start_o,
                            longint end_o, longint val);
      token_word_type w;
      if (run_count >= 3) return;
      w.tok.kind  = kind;
      w.tok.err   = err;
      w.tok.start = 20'(start_o);
      w.tok.len   = 21'((end_o >= start_o) ? end_o - start_o : 0);
      w.tok.line  = 16'(line_cnt);
      w.tok.val   = 31'(val);
      w.last      = 1'b0;
      expected_tokens = {expected_tokens, w};
      run_count++;
   endtask

   task automatic emit(logic [5:0] kind, longint end_o, longint val);
      add_token(kind, slt_pkg::E_OK, lex_start, end_o, val);
   endtask

   task automatic raise(logic [2:0] err, longint end_o);
      add_token(6'd0, err, lex_start, end_o, 0);
      halted = 1'b1;
      mode   = LM_IDLE;
   endtask

   task automatic narrow_keywords(longint pos, logic [7:0] b);
      for (int k = 0; k < slt_pkg::KW_COUNT; k++)
         if (pos >= KW_WORDS[k].len() || KW_WORDS[k][int'(pos)] != b) kw_mask[k] = 1'b0;
   endtask

   task automatic close_ident(longint end_o);
      longint     n;
      logic [5:0] kind;
      n    = (end_o >= lex_start) ? end_o - lex_start : 0;
      kind = slt_pkg::K_IDENT;
      for (int k = 0; k < slt_pkg::KW_COUNT; k++)
         if (kw_mask[k] && n == KW_WORDS[k].len()) kind = slt_pkg::K_KW0 + 6'(k);
      emit(kind, end_o, 0);
   endtask

   function automatic bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   task automatic start_lexeme(logic [7:0] b, longint cur, longint nxt);
      lex_start = (cur < SRC_MAX - 1) ? cur : SRC_MAX - 1;
      case (b)
         "(": emit(slt_pkg::K_LPAREN, nxt, 0);
         ")": emit(slt_pkg::K_RPAREN, nxt, 0);
         "{": emit(slt_pkg::K_LBRACE, nxt, 0);
         "}": emit(slt_pkg::K_RBRACE, nxt, 0);
         "[": emit(slt_pkg::K_LBRACK, nxt, 0);
         "]": emit(slt_pkg::K_RBRACK, nxt, 0);
         ",": emit(slt_pkg::K_COMMA, nxt, 0);
         "-": emit(slt_pkg::K_MINUS, nxt, 0);
         "+": emit(slt_pkg::K_PLUS, nxt, 0);
         ";": emit(slt_pkg::K_SEMI, nxt, 0);
         "*": emit(slt_pkg::K_STAR, nxt, 0);
         "!": mode = LM_BANG;
         "=": mode = LM_EQ;
         "<": mode = LM_LT;
         ">": mode = LM_GT;
         "/": mode = LM_SLASH;
         " ", 8'h0D, 8'h09: ;
         8'h0A: if (line_cnt < slt_pkg::MAX_LINE) line_cnt++;
         "'": mode = LM_CH_OPEN;
         "\"": mode = LM_STRING;
         default: begin
            if (is_digit(b)) begin
               num_acc = b - "0";
               mode    = LM_NUMBER;
            end else if (is_letter(b)) begin
               kw_mask = '1;
               narrow_keywords(0, b);
               mode = LM_IDENT;
            end else begin
               raise(slt_pkg::E_UNEXPECTED, nxt);
            end
         end
      endcase
   endtask

   task automatic scan_byte(logic [7:0] b);
      longint     cur, nxt, v;
      logic [5:0] base;
      cur = rd_off;
      nxt = (cur < SRC_MAX) ? cur + 1 : SRC_MAX;
      case (mode)
         LM_IDLE: start_lexeme(b, cur, nxt);
         LM_BANG, LM_EQ, LM_LT, LM_GT: begin
            base = (mode == LM_BANG) ? slt_pkg::K_BANG : (mode == LM_EQ) ? slt_pkg::K_EQ :
                   (mode == LM_LT) ? slt_pkg::K_LT : slt_pkg::K_GT;
            mode = LM_IDLE;
            if (b == "=") emit(base + 6'd1, nxt, 0);
            else begin
               emit(base, cur, 0);
               start_lexeme(b, cur, nxt);
            end
         end
         LM_SLASH: begin
            if (b == "/") mode = LM_COMMENT;
            else begin
               mode = LM_IDLE;
               emit(slt_pkg::K_SLASH, cur, 0);
               start_lexeme(b, cur, nxt);
            end
         end
         LM_COMMENT: begin
            if (b == 8'h0A) begin
               mode = LM_IDLE;
               start_lexeme(b, cur, nxt);
            end
         end
         LM_IDENT: begin
            if (is_letter(b) || is_digit(b)) narrow_keywords(cur - lex_start, b);
            else begin
               mode = LM_IDLE;
               close_ident(cur);
               start_lexeme(b, cur, nxt);
            end
         end
         LM_NUMBER: begin
            if (is_digit(b)) begin
               v = num_acc * 10 + (b - "0");
               if (v > 64'd2147483647) raise(slt_pkg::E_OVERFLOW, nxt);
               else num_acc = v;
            end else begin
               mode = LM_IDLE;
               emit(slt_pkg::K_NUMBER, cur, num_acc);
               start_lexeme(b, cur, nxt);
            end
         end
         LM_STRING: begin
            if (b == "\"") begin
               mode = LM_IDLE;
               emit(slt_pkg::K_STRING, nxt, 0);
            end else if (b == 8'h0A && line_cnt < slt_pkg::MAX_LINE) line_cnt++;
         end
         LM_CH_OPEN: begin
            if (b == "\\") mode = LM_CH_ESC;
            else begin
               ch_val = b;
               mode   = LM_CH_CLOSE;
            end
         end
         LM_CH_ESC: begin
            if (b == "'") begin
               ch_val = "'";
               mode   = LM_CH_CLOSE;
            end else if (b == "n") begin
               ch_val = 8'h0A;
               mode   = LM_CH_CLOSE;
            end else raise(slt_pkg::E_BAD_ESC, nxt);
         end
         default: begin
            if (b == "'") begin
               mode = LM_IDLE;
               emit(slt_pkg::K_NUMBER, nxt, ch_val);
            end else raise(slt_pkg::E_BAD_CHAR, cur);
         end
      endcase
      rd_off = nxt;
   endtask

   task automatic end_source();
      longint e;
      e = rd_off;
      if (!halted) begin
         case (mode)
            LM_BANG:   emit(slt_pkg::K_BANG, e, 0);
            LM_EQ:     emit(slt_pkg::K_EQ, e, 0);
            LM_LT:     emit(slt_pkg::K_LT, e, 0);
            LM_GT:     emit(slt_pkg::K_GT, e, 0);
            LM_SLASH:  emit(slt_pkg::K_SLASH, e, 0);
            LM_IDENT:  close_ident(e);
            LM_NUMBER: emit(slt_pkg::K_NUMBER, e, num_acc);
            LM_STRING: raise(slt_pkg::E_OPEN_STR, e);
            LM_CH_OPEN, LM_CH_CLOSE: raise(slt_pkg::E_BAD_CHAR, e);
            LM_CH_ESC: raise(slt_pkg::E_BAD_ESC, e);
            default: ;
         endcase
      end
      lex_start = (e < SRC_MAX - 1) ? e : SRC_MAX - 1;
      emit(slt_pkg::K_EOF, lex_start, 0);
      clear_lexer();
   endtask

   task automatic lex_word(logic [7:0] b, bit has, bit eos);
      run_count = 0;
      if (has) begin
         if (halted) begin
            if (rd_off < SRC_MAX) rd_off++;
         end else scan_byte(b);
      end
      if (eos) end_source();
      if (run_count > 0) expected_tokens[$].last = 1'b1;
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_token();
      token_word_type w;
      if (expected_tokens.size() == 0) begin
         report("unexpected token, kind", rsp_token_kind, -1);
         return;
      end
      w = expected_tokens.pop_front();
      if (rsp_token_kind != w.tok.kind) report("token_kind", rsp_token_kind, w.tok.kind);
      if (rsp_error_code != w.tok.err) report("error_code", rsp_error_code, w.tok.err);
      if (rsp_start_offset != w.tok.start)
         report("start_offset", rsp_start_offset, w.tok.start);
      if (rsp_text_length != w.tok.len) report("text_length", rsp_text_length, w.tok.len);
      if (rsp_line_number != w.tok.line) report("line_number", rsp_line_number, w.tok.line);
      if (rsp_number_value != w.tok.val)
         report("number_value", rsp_number_value, w.tok.val);
      if (rsp_last_of_run != w.last) report("last_of_run", rsp_last_of_run, w.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_lexer();
         expected_tokens.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_token();
         if (req_push && !req_full) lex_word(req_data_byte, req_has_byte, req_end_of_source);
      end
      pending = expected_tokens.size();
   end

endmodule

FILE: tb/tb_source_lexer_tokenizer_core.sv
// Testbench top: drives source bytes into the lexer and gives the verdict.
`timescale 1ns / 100ps
module tb_source_lexer_tokenizer_core;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_end_of_source;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [5:0]  rsp_token_kind;
   logic [2:0]  rsp_error_code;
   logic [19:0] rsp_start_offset;
   logic [20:0] rsp_text_length;
   logic [15:0] rsp_line_number;
   logic [30:0] rsp_number_value;
   logic        rsp_last_of_run;
   int          fail_count;
   int          pending;
   int          tx_idle_pct;
   int          rx_idle_pct;
   int          words_sent;

   localparam int LEXEME_COUNT = 55;
   localparam string LEXEMES [LEXEME_COUNT] = '{
      "and", "else", "fun", "if", "or", "putc", "return", "var", "while",
      "an", "andx", "_x9", "Foo", "whilee", "i", "0", "7", "2147483647",
      "2147483648", "99999999999", "(", ")", "{", "}", "[", "]", ",", "-",
      "+", ";", "*", "!", "!=", "=", "==", "<", "<=", ">", ">=", "/",
      "// note\n", "\"a b\"", "\"x\ny\"", "'a'", "'\\n'", "'\\''", "'\\q'",
      "'ab'", "'\n'", "\n", "\t", "\015", "@", "\"open", "'\\"};

   source_lexer_tokenizer_core u_top (.*);

   token_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) rsp_pop <= ($urandom_range(99) >= rx_idle_pct);

   task automatic send_word(logic [7:0] b, bit has, bit eos);
      // idle the sender cycle by cycle at the current percentage
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_data_byte     <= b;
      req_has_byte      <= has;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_full);
      words_sent++;
   endtask

   task automatic send_text(string s, bit eos_last);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, eos_last && i == s.len() - 1);
   endtask

   // one source: mostly well-formed lexemes, sometimes raw noise bytes
   task automatic send_source();
      int n;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b1, 1'b0);
         else send_text(LEXEMES[$urandom_range(LEXEME_COUNT - 1)], 1'b0);
         if ($urandom_range(2) == 0) send_word(" ", 1'b1, 1'b0);
         if ($urandom_range(15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      end
      if ($urandom_range(1)) send_word(8'($urandom), 1'b0, 1'b1);
      else send_text(LEXEMES[$urandom_range(LEXEME_COUNT - 1)], 1'b1);
   endtask

   initial begin
      reset             = 1'b1;
      req_push          = 1'b0;
      req_data_byte     = 8'd0;
      req_has_byte      = 1'b0;
      req_end_of_source = 1'b0;
      tx_idle_pct       = 8;
      rx_idle_pct       = 87;
      words_sent        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: keyword, operators, largest number, bad bytes, open tokens at end
      send_text("if(x>=2147483647)", 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      send_text("'\\", 1'b1);
      send_text("\"s", 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 87 : 0;
         rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 8 : 0;
         words_sent  = 0;
         while (words_sent < 135) send_source();
      end
      req_push <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
sv/slt_pkg.sv
sv/slt_front.sv
sv/slt_queue.sv
sv/slt_back.sv
sv/source_lexer_tokenizer_core.sv
tb/token_checker.sv
tb/tb_source_lexer_tokenizer_core.sv
